[sv/box_average_downscaler_assert.svh]
// Assertion macros for the box average downscaler.
// Used by box_average_downscaler.sv; expects clk_i and rst_ni in scope.
`ifndef BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALER_ASSERT_SVH

`ifndef SYNTHESIS
`define BXAVG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BXAVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BXAVG_ASSERT_IMPL(label, ante, cons, msg)
`define BXAVG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/bxavg_pkg.sv]
// Shared types and constants for the box average downscaler.
// No dependencies; the files that use it refer to it by scoped names.
package bxavg_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned AvgW     = 8;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned ScaleW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ProdW    = 2 * ScaleW;
  localparam int unsigned ColW     = WidthW + 1;
  localparam int unsigned RowW     = HeightW + 1;

  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned DefMaxWidth = 1024;
  localparam int unsigned DefMaxScale = 16;
  localparam int unsigned MidDepth    = 4;

  localparam int unsigned RstImageWidth  = 640;
  localparam int unsigned RstImageHeight = 480;
  localparam int unsigned RstScaleX      = 2;
  localparam int unsigned RstScaleY      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegScaleX      = 2'd2,
    RegScaleY      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WidthW-1:0]  image_width;
    logic [HeightW-1:0] image_height;
    logic [ScaleW-1:0]  scale_x;
    logic [ScaleW-1:0]  scale_y;
  } cfg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

endpackage

[sv/bxavg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bxavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/bxavg_fifo.sv]
// Small register queue between the front and back ends of the downscaler.
// No dependencies.
module bxavg_fifo #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = CntW'(count_q + 1'b1);
      2'b01:   count_d = CntW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

[sv/bxavg_front.sv]
// Front end: frame position tracking, horizontal sums and the line buffer of block sums.
// Depends on bxavg_pkg and bxavg_ram.
module bxavg_front #(
  parameter int unsigned MAX_WIDTH = bxavg_pkg::DefMaxWidth,
  parameter int unsigned MAX_SCALE = bxavg_pkg::DefMaxScale
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bxavg_pkg::cfg_t      cfg_i,
  input  logic                 restart_i,
  input  logic                 accept_i,
  input  logic [bxavg_pkg::PixW-1:0] pixel_i,
  output logic                 push_o,
  output logic [$clog2(MAX_SCALE*MAX_SCALE*255+1)-1:0] sum_o,
  output bxavg_pkg::flags_t    flags_o
);

  localparam int unsigned ColW   = bxavg_pkg::ColW;
  localparam int unsigned RowW   = bxavg_pkg::RowW;
  localparam int unsigned ScaleW = bxavg_pkg::ScaleW;
  localparam int unsigned AddrW  = $clog2(MAX_WIDTH);
  localparam int unsigned HSumW  = $clog2(MAX_SCALE * 255 + 1);
  localparam int unsigned SumW   = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);

  logic [HSumW-1:0]  hsum_q, hsum_d;
  logic [ColW-1:0]   in_col_q, in_col_d, blk_col_q, blk_col_d;
  logic [RowW-1:0]   in_row_q, in_row_d, band_row_q, band_row_d;
  logic [ScaleW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [AddrW-1:0]  out_col_q, out_col_d;

  logic              s2_valid_q, s2_first_q, s2_emit_q;
  bxavg_pkg::flags_t s2_flags_q;
  logic [AddrW-1:0]  s2_addr_q;
  logic [HSumW-1:0]  s2_hsum_q;

  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [SumW-1:0]   fwd_data_q;

  logic [ColW-1:0]   sx_c, wid_c;
  logic [RowW-1:0]   sy_r, hgt_r;
  logic              col_fit, row_fit, active, blk_done, last_col, last_row, row_end;
  logic [HSumW-1:0]  hsum_add;
  logic [SumW-1:0]   ram_rdata, prev_sum, col_sum;

  always_comb begin
    sx_c     = ColW'(cfg_i.scale_x);
    wid_c    = ColW'(cfg_i.image_width);
    sy_r     = RowW'(cfg_i.scale_y);
    hgt_r    = RowW'(cfg_i.image_height);
    col_fit  = ColW'(blk_col_q + sx_c) <= wid_c;
    row_fit  = RowW'(band_row_q + sy_r) <= hgt_r;
    active   = col_fit && row_fit;
    hsum_add = HSumW'(hsum_q + HSumW'(pixel_i));
    blk_done = active && (ScaleW'(dx_q + 1'b1) == cfg_i.scale_x);
    last_col = ColW'(blk_col_q + (sx_c << 1)) > wid_c;
    last_row = RowW'(band_row_q + (sy_r << 1)) > hgt_r;
    row_end  = ColW'(in_col_q + 1'b1) >= wid_c;
  end

  always_comb begin
    hsum_d     = hsum_q;
    in_col_d   = in_col_q;
    blk_col_d  = blk_col_q;
    in_row_d   = in_row_q;
    band_row_d = band_row_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    out_col_d  = out_col_q;
    if (restart_i) begin
      hsum_d     = '0;
      in_col_d   = '0;
      blk_col_d  = '0;
      in_row_d   = '0;
      band_row_d = '0;
      dx_d       = '0;
      dy_d       = '0;
      out_col_d  = '0;
    end else if (accept_i) begin
      if (active) begin
        hsum_d = hsum_add;
        dx_d   = ScaleW'(dx_q + 1'b1);
        if (blk_done) begin
          hsum_d    = '0;
          dx_d      = '0;
          blk_col_d = ColW'(blk_col_q + sx_c);
          out_col_d = AddrW'(out_col_q + 1'b1);
        end
      end
      in_col_d = ColW'(in_col_q + 1'b1);
      if (row_end) begin
        in_col_d  = '0;
        out_col_d = '0;
        hsum_d    = '0;
        dx_d      = '0;
        blk_col_d = '0;
        if (row_fit) begin
          if (ScaleW'(dy_q + 1'b1) == cfg_i.scale_y) begin
            dy_d       = '0;
            band_row_d = RowW'(band_row_q + sy_r);
          end else begin
            dy_d = ScaleW'(dy_q + 1'b1);
          end
        end
        in_row_d = RowW'(in_row_q + 1'b1);
        if (RowW'(in_row_q + 1'b1) >= hgt_r) begin
          in_row_d   = '0;
          dy_d       = '0;
          band_row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsum_q      <= '0;
      in_col_q    <= '0;
      blk_col_q   <= '0;
      in_row_q    <= '0;
      band_row_q  <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      out_col_q   <= '0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      hsum_q      <= hsum_d;
      in_col_q    <= in_col_d;
      blk_col_q   <= blk_col_d;
      in_row_q    <= in_row_d;
      band_row_q  <= band_row_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      out_col_q   <= out_col_d;
      s2_valid_q  <= accept_i && blk_done && !restart_i;
      fwd_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && blk_done) begin
      s2_first_q           <= (dy_q == '0);
      s2_emit_q            <= (ScaleW'(dy_q + 1'b1) == cfg_i.scale_y);
      s2_flags_q.row_end   <= last_col;
      s2_flags_q.frame_end <= last_col && last_row;
      s2_addr_q            <= out_col_q;
      s2_hsum_q            <= hsum_add;
    end
    if (s2_valid_q) begin
      fwd_addr_q <= s2_addr_q;
      fwd_data_q <= col_sum;
    end
  end

  // The RAM returns old data when it is written and read at the same edge, so
  // the entry written at the edge of that read is taken from the bypass register.
  always_comb begin
    prev_sum = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : ram_rdata;
    col_sum  = s2_first_q ? SumW'(s2_hsum_q) : SumW'(prev_sum + SumW'(s2_hsum_q));
  end

  bxavg_ram #(
    .Width (SumW),
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q),
    .waddr_i (s2_addr_q),
    .wdata_i (col_sum),
    .re_i    (accept_i && blk_done),
    .raddr_i (out_col_q),
    .rdata_o (ram_rdata)
  );

  assign push_o  = s2_valid_q && s2_emit_q;
  assign sum_o   = col_sum;
  assign flags_o = s2_flags_q;

endmodule

[sv/bxavg_back.sv]
// Back end: restoring divider for block averages and the result output register.
// Depends on bxavg_pkg.
module bxavg_back #(
  parameter int unsigned MAX_SCALE = bxavg_pkg::DefMaxScale
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bxavg_pkg::cfg_t      cfg_i,
  input  logic                 fifo_empty_i,
  input  logic [$clog2(MAX_SCALE*MAX_SCALE*255+1)-1:0] fifo_sum_i,
  input  bxavg_pkg::flags_t    fifo_flags_i,
  output logic                 fifo_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [bxavg_pkg::AvgW-1:0] avg_o,
  output bxavg_pkg::flags_t    flags_o
);

  localparam int unsigned AvgW  = bxavg_pkg::AvgW;
  localparam int unsigned ProdW = bxavg_pkg::ProdW;
  localparam int unsigned SumW  = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int unsigned DenW  = ProdW + AvgW - 1;
  localparam int unsigned CmpW  = (SumW > DenW) ? SumW : DenW;
  localparam int unsigned StepW = $clog2(AvgW);

  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkDiv  = 3'b010,
    BkHold = 3'b100
  } bk_state_e;

  bk_state_e         state_q, state_d;
  logic [ProdW-1:0]  prod_q;
  logic [SumW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [AvgW-1:0]   quo_q, quo_d;
  logic [StepW-1:0]  step_q, step_d;
  bxavg_pkg::flags_t flags_q, flags_d;
  logic              out_valid_q, out_valid_d, out_load;
  logic [AvgW-1:0]   out_avg_q;
  bxavg_pkg::flags_t out_flags_q;
  logic              fits;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    step_d      = step_q;
    flags_d     = flags_q;
    fifo_pop_o  = 1'b0;
    out_load    = 1'b0;
    fits        = CmpW'(rem_q) >= CmpW'(den_q);
    out_valid_d = out_valid_q && !pop_i;
    case (state_q)
      BkIdle: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          rem_d      = fifo_sum_i;
          den_d      = DenW'(prod_q) << (AvgW - 1);
          quo_d      = '0;
          step_d     = '0;
          flags_d    = fifo_flags_i;
          state_d    = BkDiv;
        end
      end
      BkDiv: begin
        if (fits) begin
          rem_d = SumW'(CmpW'(rem_q) - CmpW'(den_q));
        end
        quo_d  = {quo_q[AvgW-2:0], fits};
        den_d  = den_q >> 1;
        step_d = StepW'(step_q + 1'b1);
        if (step_q == StepW'(AvgW - 1)) begin
          state_d = BkHold;
        end
      end
      BkHold: begin
        if (!out_valid_q || pop_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= ProdW'(cfg_i.scale_x * cfg_i.scale_y);
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    flags_q <= flags_d;
    if (out_load) begin
      out_avg_q   <= quo_q;
      out_flags_q <= flags_q;
    end
  end

  assign empty_o = !out_valid_q;
  assign avg_o   = out_avg_q;
  assign flags_o = out_flags_q;

endmodule

[sv/box_average_downscaler.sv]
// Top level of the box average downscaler: configuration registers, front end,
// queue and back end. Depends on bxavg_pkg, bxavg_front, bxavg_fifo, bxavg_back
// and box_average_downscaler_assert.svh.
//
//   Channel   Dir  Handshake                  Payload
//   pixels    in   push / full                pixel_value_i
//   results   out  empty / pop                avg_pixel_o, row_end_o, frame_end_o
//   config    in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A pixel is taken in each cycle with push high and full low; if it completes a block, its
// line buffer update lands in the following cycle. The back end gives each block one
// fetch, eight restoring division steps and one output load, and fetches no new block
// before that load; full rises once the four-entry queue, with any pending push, is full.
// Reset sets 640 by 480 pixels with 2 by 2 blocks; a configuration transaction restarts
// the frame position and keeps the line buffer. The configuration channel is always ready.
`include "box_average_downscaler_assert.svh"

module box_average_downscaler #(
  parameter int unsigned MAX_WIDTH = bxavg_pkg::DefMaxWidth,
  parameter int unsigned MAX_SCALE = bxavg_pkg::DefMaxScale
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [bxavg_pkg::PixW-1:0]     pixel_value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [bxavg_pkg::AvgW-1:0]     avg_pixel_o,
  output logic                           row_end_o,
  output logic                           frame_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bxavg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bxavg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WidthW   = bxavg_pkg::WidthW;
  localparam int unsigned HeightW  = bxavg_pkg::HeightW;
  localparam int unsigned ScaleW   = bxavg_pkg::ScaleW;
  localparam int unsigned SumW     = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int unsigned MidDepth = bxavg_pkg::MidDepth;
  localparam int unsigned MidCntW  = $clog2(MidDepth + 1);
  localparam int unsigned MidW     = SumW + $bits(bxavg_pkg::flags_t);

  bxavg_pkg::cfg_t   cfg_q, cfg_d;
  logic              cfg_we, accept;
  logic [WidthW-1:0]  w_raw;
  logic [HeightW-1:0] h_raw;
  logic [ScaleW-1:0]  s_raw, s_clamp;

  logic              mid_push, mid_pop, mid_empty;
  logic [SumW-1:0]   front_sum, back_sum;
  bxavg_pkg::flags_t front_flags, back_flags, out_flags;
  logic [MidCntW-1:0] mid_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push && !full;

  always_comb begin
    w_raw   = cfg_data_i[WidthW-1:0];
    h_raw   = cfg_data_i[HeightW-1:0];
    s_raw   = cfg_data_i[ScaleW-1:0];
    s_clamp = s_raw;
    if (s_raw == '0) begin
      s_clamp = ScaleW'(1);
    end else if (32'(s_raw) > MAX_SCALE) begin
      s_clamp = ScaleW'(MAX_SCALE);
    end
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (bxavg_pkg::cfg_reg_e'(cfg_index_i))
        bxavg_pkg::RegImageWidth: begin
          if (w_raw == '0) begin
            cfg_d.image_width = WidthW'(1);
          end else if (32'(w_raw) > MAX_WIDTH) begin
            cfg_d.image_width = WidthW'(MAX_WIDTH);
          end else begin
            cfg_d.image_width = w_raw;
          end
        end
        bxavg_pkg::RegImageHeight: begin
          if (h_raw == '0) begin
            cfg_d.image_height = HeightW'(1);
          end else if (32'(h_raw) > bxavg_pkg::MaxHeight) begin
            cfg_d.image_height = HeightW'(bxavg_pkg::MaxHeight);
          end else begin
            cfg_d.image_height = h_raw;
          end
        end
        bxavg_pkg::RegScaleX: cfg_d.scale_x = s_clamp;
        bxavg_pkg::RegScaleY: cfg_d.scale_y = s_clamp;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WidthW'(bxavg_pkg::RstImageWidth);
      cfg_q.image_height <= HeightW'(bxavg_pkg::RstImageHeight);
      cfg_q.scale_x      <= ScaleW'(bxavg_pkg::RstScaleX);
      cfg_q.scale_y      <= ScaleW'(bxavg_pkg::RstScaleY);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Room is kept for the block sum that the front end may still push.
  assign full = (32'(mid_count) + 32'(mid_push)) >= MidDepth;

  bxavg_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (cfg_we),
    .accept_i  (accept),
    .pixel_i   (pixel_value_i),
    .push_o    (mid_push),
    .sum_o     (front_sum),
    .flags_o   (front_flags)
  );

  bxavg_fifo #(
    .Width (MidW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({front_flags, front_sum}),
    .pop_i   (mid_pop),
    .data_o  ({back_flags, back_sum}),
    .count_o (mid_count)
  );

  assign mid_empty = (mid_count == '0);

  bxavg_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (mid_empty),
    .fifo_sum_i   (back_sum),
    .fifo_flags_i (back_flags),
    .fifo_pop_o   (mid_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .avg_o        (avg_pixel_o),
    .flags_o      (out_flags)
  );

  assign row_end_o   = out_flags.row_end;
  assign frame_end_o = out_flags.frame_end;

  `BXAVG_ASSERT_IMPL(a_mid_no_overflow, mid_push, (mid_count != MidCntW'(MidDepth)) || mid_pop, "block sum pushed into a full queue")
  `BXAVG_ASSERT_IMPL(a_mid_pop_nonempty, mid_pop, !mid_empty, "back end popped an empty queue")
  `BXAVG_ASSERT_NEXT(a_cfg_no_push, cfg_we && !mid_push, !mid_push, "block sum produced right after a configuration transaction")

endmodule
